/* rtl/core/c2p_pkg.sv */
// ============================================================================
// c2p_pkg
// Shared types, widths and constants for the Cartesian-to-polar converter.
// ============================================================================
package c2p_pkg;

    // Coordinate width is fixed by the item format.
    localparam int COORD_WIDTH = 16;

    // Defaults for the top-level parameters.
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 18;

    // Angle accumulator fraction bits (degrees) and vector guard bits.
    localparam int Z_FRAC     = 24;
    localparam int GUARD_BITS = 16;

    // CORDIC vector width: magnitude grows by the gain and by sqrt(2).
    localparam int CW = COORD_WIDTH + GUARD_BITS + 3;
    // Angle accumulator width (signed), folded angle width (unsigned).
    localparam int Z_W = 33;
    localparam int FW  = 34;

    // Square root: one root bit per pair of the scaled sum of squares.
    localparam int ROOT_PAIRS = COORD_WIDTH + 4;
    localparam int REM_W      = ROOT_PAIRS + 3;
    localparam int T_W        = 2 * COORD_WIDTH + 8;

    // Output field widths.
    localparam int QUAD_W   = 3;
    localparam int RADIUS_W = 20;
    localparam int ANGLE_W  = 17;

    // Quadrant codes.
    localparam logic [QUAD_W-1:0] QUAD_FIRST  = 3'd1;
    localparam logic [QUAD_W-1:0] QUAD_SECOND = 3'd2;
    localparam logic [QUAD_W-1:0] QUAD_THIRD  = 3'd3;
    localparam logic [QUAD_W-1:0] QUAD_FOURTH = 3'd4;

    // Angles in accumulator units.
    localparam logic [FW-1:0] DEG90  = FW'(90)  << Z_FRAC;
    localparam logic [FW-1:0] DEG180 = FW'(180) << Z_FRAC;
    localparam logic [FW-1:0] DEG360 = FW'(360) << Z_FRAC;

    // atan(2^-i) in units of 2^-24 degree, rounded to nearest.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115,
        32'd57,        32'd29,        32'd14,        32'd7,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // One input item.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
    } coord_item_t;

    // One result item.
    typedef struct packed {
        logic [QUAD_W-1:0]   quadrant;
        logic [RADIUS_W-1:0] radius;
        logic [ANGLE_W-1:0]  angle;
    } polar_item_t;

    // Per-item control that rides alongside the datapath.
    typedef struct packed {
        logic [QUAD_W-1:0] quadrant;
        logic              x_zero;
        logic              y_zero;
    } c2p_ctrl_t;

endpackage

/* rtl/core/cartesian_to_polar_top.sv */
// ============================================================================
// cartesian_to_polar_top
// Pipelined Cartesian-to-polar converter: quadrant, rounded radius and angle.
// ============================================================================
//
//  Channel | Valid        | Stall        | Payload             | Direction
//  --------+--------------+--------------+---------------------+----------
//  coord   | coord_valid  | coord_stall  | coord (x, y)        | in
//  polar   | polar_valid  | polar_stall  | polar (quad, r, th) | out
//
//  One item is accepted per cycle while coord_stall is low. The number of
//  loop stages is set by the longer of the CORDIC rotation chain and the
//  20-digit square-root chain, one step of each per stage.
//  Reset clears only the valid bits; there is no clearing pass.
//  A stalled result moves into a skid register, and the pipeline holds
//  (coord_stall high) only while that register is full.
//
module cartesian_to_polar_top
    import c2p_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        coord_valid,
    output logic        coord_stall,
    input  coord_item_t coord,
    output logic        polar_valid,
    input  logic        polar_stall,
    output polar_item_t polar
);

    localparam int LOOP_STAGES = (CORDIC_STAGES > ROOT_PAIRS) ? CORDIC_STAGES : ROOT_PAIRS;
    localparam int SH          = Z_FRAC - ANGLE_FRAC_BITS;
    localparam logic [FW-1:0] HALF_LSB  = FW'(1) << (SH - 1);
    localparam logic [FW-1:0] FULL_TURN = FW'(360) << ANGLE_FRAC_BITS;
    localparam int RAD_X = (ROOT_PAIRS + 1 > RADIUS_W) ? ROOT_PAIRS + 1 : RADIUS_W;

    logic en;

    // Stage 0: magnitudes and quadrant.
    logic                   s0_valid_reg;
    c2p_ctrl_t              s0_ctrl_reg, s0_ctrl_next;
    logic [COORD_WIDTH-1:0] s0_ax_reg, s0_ax_next;
    logic [COORD_WIDTH-1:0] s0_ay_reg, s0_ay_next;

    // Stage 1: squares.
    logic                     s1_valid_reg;
    c2p_ctrl_t                s1_ctrl_reg;
    logic [COORD_WIDTH-1:0]   s1_ax_reg, s1_ay_reg;
    logic [2*COORD_WIDTH-1:0] s1_sqx_reg, s1_sqy_reg;

    // Stage 2: sum of squares and CORDIC start vector.
    logic                     s2_valid_reg;
    c2p_ctrl_t                s2_ctrl_reg;
    logic signed [CW-1:0]     s2_cx_reg, s2_cy_reg;
    logic [2*COORD_WIDTH-1:0] s2_sum_reg;

    // Links between loop stages.
    logic                  v_link    [LOOP_STAGES+1];
    c2p_ctrl_t             ctrl_link [LOOP_STAGES+1];
    logic signed [CW-1:0]  cx_link   [LOOP_STAGES+1];
    logic signed [CW-1:0]  cy_link   [LOOP_STAGES+1];
    logic signed [Z_W-1:0] z_link    [LOOP_STAGES+1];
    logic [T_W-1:0]        t_link    [LOOP_STAGES+1];
    logic [REM_W-1:0]      rem_link  [LOOP_STAGES+1];
    logic [ROOT_PAIRS-1:0] root_link [LOOP_STAGES+1];

    // Fold stage.
    logic                  f1_valid_reg;
    logic [QUAD_W-1:0]     f1_quad_reg;
    logic [FW-1:0]         f1_full_reg, f1_full_next;
    logic [RAD_X-1:0]      f1_rad_reg, f1_rad_next;
    logic [FW-1:0]         qa_angle;

    // Rounding stage, which is the pipeline's last register.
    logic                  f2_valid_reg;
    polar_item_t           f2_item_reg, f2_item_next;
    logic [FW-1:0]         rounded;

    // Skid register for a result that waits.
    logic                  skid_valid_reg, skid_valid_next;
    polar_item_t           skid_item_reg;

    // The pipeline moves whenever the skid register is empty.
    assign en          = !skid_valid_reg;
    assign coord_stall = skid_valid_reg;

    // Stage 0 logic: absolute values and sign test.
    always_comb
    begin
        logic x_neg, y_neg;
        x_neg = coord.coord_x[COORD_WIDTH-1];
        y_neg = coord.coord_y[COORD_WIDTH-1];
        s0_ax_next = x_neg ? (~coord.coord_x + 1'b1) : coord.coord_x;
        s0_ay_next = y_neg ? (~coord.coord_y + 1'b1) : coord.coord_y;
        if (x_neg)
        begin
            s0_ctrl_next.quadrant = y_neg ? QUAD_THIRD : QUAD_SECOND;
        end
        else
        begin
            s0_ctrl_next.quadrant = y_neg ? QUAD_FOURTH : QUAD_FIRST;
        end
        s0_ctrl_next.x_zero = (coord.coord_x == '0);
        s0_ctrl_next.y_zero = (coord.coord_y == '0);
    end

    // Valid bits of the front and back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= coord_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            f1_valid_reg <= v_link[LOOP_STAGES];
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // Front stages: magnitudes, squares, then sum and start vector.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctrl_reg <= s0_ctrl_next;
            s0_ax_reg   <= s0_ax_next;
            s0_ay_reg   <= s0_ay_next;

            s1_ctrl_reg <= s0_ctrl_reg;
            s1_ax_reg   <= s0_ax_reg;
            s1_ay_reg   <= s0_ay_reg;
            s1_sqx_reg  <= s0_ax_reg * s0_ax_reg;
            s1_sqy_reg  <= s0_ay_reg * s0_ay_reg;

            s2_ctrl_reg <= s1_ctrl_reg;
            s2_sum_reg  <= s1_sqx_reg + s1_sqy_reg;
            s2_cx_reg   <= signed'(CW'({s1_ax_reg, {GUARD_BITS{1'b0}}}));
            s2_cy_reg   <= signed'(CW'({s1_ay_reg, {GUARD_BITS{1'b0}}}));
        end
    end

    // Start of the loop chain.
    assign v_link[0]    = s2_valid_reg;
    assign ctrl_link[0] = s2_ctrl_reg;
    assign cx_link[0]   = s2_cx_reg;
    assign cy_link[0]   = s2_cy_reg;
    assign z_link[0]    = '0;
    assign t_link[0]    = {s2_sum_reg, 8'b0};
    assign rem_link[0]  = '0;
    assign root_link[0] = '0;

    // Loop stages: one rotation and one root digit each; a stage past either chain passes that part through.
    generate
        for (genvar k = 0; k < LOOP_STAGES; k++) begin : g_loop
            c2p_stage #(
                .STAGE_IDX     (k),
                .CORDIC_STAGES (CORDIC_STAGES)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (v_link[k]),
                .ctrl_in   (ctrl_link[k]),
                .cx_in     (cx_link[k]),
                .cy_in     (cy_link[k]),
                .z_in      (z_link[k]),
                .t_in      (t_link[k]),
                .rem_in    (rem_link[k]),
                .root_in   (root_link[k]),
                .valid_out (v_link[k+1]),
                .ctrl_out  (ctrl_link[k+1]),
                .cx_out    (cx_link[k+1]),
                .cy_out    (cy_link[k+1]),
                .z_out     (z_link[k+1]),
                .t_out     (t_link[k+1]),
                .rem_out   (rem_link[k+1]),
                .root_out  (root_link[k+1])
            );
        end
    endgenerate

    // Fold logic: clamp, axis cases, quadrant fold and radius rounding.
    always_comb
    begin
        c2p_ctrl_t             c;
        logic signed [Z_W-1:0] z;
        c = ctrl_link[LOOP_STAGES];
        z = z_link[LOOP_STAGES];
        if (c.y_zero)
        begin
            qa_angle = '0;
        end
        else if (c.x_zero)
        begin
            qa_angle = DEG90;
        end
        else if (z[Z_W-1])
        begin
            qa_angle = '0;
        end
        else if (FW'(z) > DEG90)
        begin
            qa_angle = DEG90;
        end
        else
        begin
            qa_angle = FW'(z);
        end

        unique case (c.quadrant)
            QUAD_SECOND: f1_full_next = DEG180 - qa_angle;
            QUAD_THIRD:  f1_full_next = DEG180 + qa_angle;
            QUAD_FOURTH: f1_full_next = DEG360 - qa_angle;
            default:     f1_full_next = qa_angle;
        endcase

        if (rem_link[LOOP_STAGES] > REM_W'(root_link[LOOP_STAGES]))
        begin
            f1_rad_next = RAD_X'(root_link[LOOP_STAGES]) + 1'b1;
        end
        else
        begin
            f1_rad_next = RAD_X'(root_link[LOOP_STAGES]);
        end
    end

    // Round half up to the output fraction bits and wrap a full turn to zero.
    always_comb
    begin
        logic [FW-1:0] wrapped;
        rounded = (f1_full_reg + HALF_LSB) >> SH;
        wrapped = (rounded >= FULL_TURN) ? (rounded - FULL_TURN) : rounded;
        f2_item_next.quadrant = f1_quad_reg;
        f2_item_next.radius   = f1_rad_reg[RADIUS_W-1:0];
        f2_item_next.angle    = wrapped[ANGLE_W-1:0];
    end

    // Back stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_quad_reg <= ctrl_link[LOOP_STAGES].quadrant;
            f1_full_reg <= f1_full_next;
            f1_rad_reg  <= f1_rad_next;
            f2_item_reg <= f2_item_next;
        end
    end

    // Skid control: catch the last item when the output stalls.
    always_comb
    begin
        if (skid_valid_reg)
        begin
            skid_valid_next = polar_stall;
        end
        else
        begin
            skid_valid_next = f2_valid_reg && polar_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_item_reg <= f2_item_reg;
        end
    end

    // Output: the skid register has priority while it holds an item.
    assign polar_valid = skid_valid_reg || f2_valid_reg;
    assign polar       = skid_valid_reg ? skid_item_reg : f2_item_reg;

endmodule

/* rtl/core/c2p_stage.sv */
// ============================================================================
// c2p_stage
// One pipeline stage: a CORDIC vectoring rotation and one square-root digit, each passed past its chain's end.
// ============================================================================
module c2p_stage
    import c2p_pkg::*;
#(
    parameter int STAGE_IDX     = 0,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  c2p_ctrl_t              ctrl_in,
    input  logic signed [CW-1:0]   cx_in,
    input  logic signed [CW-1:0]   cy_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  logic [T_W-1:0]         t_in,
    input  logic [REM_W-1:0]       rem_in,
    input  logic [ROOT_PAIRS-1:0]  root_in,
    output logic                   valid_out,
    output c2p_ctrl_t              ctrl_out,
    output logic signed [CW-1:0]   cx_out,
    output logic signed [CW-1:0]   cy_out,
    output logic signed [Z_W-1:0]  z_out,
    output logic [T_W-1:0]         t_out,
    output logic [REM_W-1:0]       rem_out,
    output logic [ROOT_PAIRS-1:0]  root_out
);

    localparam int TAB_IDX = STAGE_IDX % 32;

    logic                  valid_reg;
    c2p_ctrl_t             ctrl_reg;
    logic signed [CW-1:0]  cx_reg, cx_next;
    logic signed [CW-1:0]  cy_reg, cy_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic [T_W-1:0]        t_reg, t_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_PAIRS-1:0] root_reg, root_next;

    // CORDIC rotation toward the x axis, or a plain pass past the last rotation.
    generate
        if (STAGE_IDX < CORDIC_STAGES) begin : g_cordic
            logic signed [CW-1:0]  dx, dy;
            logic signed [Z_W-1:0] step;
            assign dx   = cy_in >>> STAGE_IDX;
            assign dy   = cx_in >>> STAGE_IDX;
            assign step = signed'(Z_W'(ATAN_TAB[TAB_IDX]));
            always_comb
            begin
                if (!cy_in[CW-1])
                begin
                    cx_next = cx_in + dx;
                    cy_next = cy_in - dy;
                    z_next  = z_in + step;
                end
                else
                begin
                    cx_next = cx_in - dx;
                    cy_next = cy_in + dy;
                    z_next  = z_in - step;
                end
            end
        end
        else begin : g_cordic_pass
            assign cx_next = cx_in;
            assign cy_next = cy_in;
            assign z_next  = z_in;
        end
    endgenerate

    // One restoring square-root digit from the top pair of the operand.
    generate
        if (STAGE_IDX < ROOT_PAIRS) begin : g_root
            logic [REM_W-1:0] rem_sh, trial;
            assign rem_sh = {rem_in[REM_W-3:0], t_in[T_W-1 -: 2]};
            assign trial  = REM_W'({root_in, 2'b01});
            assign t_next = {t_in[T_W-3:0], 2'b00};
            always_comb
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[ROOT_PAIRS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_in[ROOT_PAIRS-2:0], 1'b0};
                end
            end
        end
        else begin : g_root_pass
            assign t_next    = t_in;
            assign rem_next  = rem_in;
            assign root_next = root_in;
        end
    endgenerate

    // Valid bit, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg <= ctrl_in;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            z_reg    <= z_next;
            t_reg    <= t_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign cx_out    = cx_reg;
    assign cy_out    = cy_reg;
    assign z_out     = z_reg;
    assign t_out     = t_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule
